// ===== src/esa_pkg.sv =====
// Shared constants and types for the error statistics accumulator.
// Used by esa_stat_unit and error_statistics_accumulator; depends on nothing.

package esa_pkg;

   // Sample, count and fraction sizes
   localparam int SAMPLE_BITS  = 20;
   localparam int COUNT_BITS   = 20;
   localparam int FRAC_BITS    = 8;

   // Derived accumulator widths
   localparam int DIFF_BITS    = SAMPLE_BITS + 1;
   localparam int SQR_BITS     = 2 * DIFF_BITS;
   localparam int ERR_SUM_BITS = DIFF_BITS + COUNT_BITS;
   localparam int SQ_SUM_BITS  = 2 * SAMPLE_BITS + COUNT_BITS + 2;

   // Result field widths
   localparam int MEAN_BITS    = 29;
   localparam int VAR_BITS     = 48;
   localparam int RMS_BITS     = 28;

   // Iterative datapath sizes
   localparam int WORK_BITS    = SQ_SUM_BITS + 2 * FRAC_BITS;
   localparam int QUOT_BITS    = 2 * RMS_BITS;
   localparam int PART_BITS    = RMS_BITS + 1;
   localparam int CS_BITS      = PART_BITS + 2;
   localparam int BSQ_BITS     = 2 * MEAN_BITS;
   localparam int B2_BITS      = BSQ_BITS - FRAC_BITS;
   localparam int STEP_BITS    = 7;

   localparam int MEAN_STEPS   = ERR_SUM_BITS + FRAC_BITS;
   localparam int MSQ_STEPS    = WORK_BITS;
   localparam int ROOT_STEPS   = RMS_BITS;

   localparam logic [STEP_BITS-1:0] MEAN_LAST = STEP_BITS'(MEAN_STEPS - 1);
   localparam logic [STEP_BITS-1:0] MSQ_LAST  = STEP_BITS'(MSQ_STEPS - 1);
   localparam logic [STEP_BITS-1:0] ROOT_LAST = STEP_BITS'(ROOT_STEPS - 1);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // Mean bias saturation limits (magnitude)
   localparam logic [QUOT_BITS-1:0] MEAN_POS_LIMIT =
      QUOT_BITS'((64'd1 << (MEAN_BITS - 1)) - 64'd1);
   localparam logic [QUOT_BITS-1:0] MEAN_NEG_LIMIT =
      QUOT_BITS'(64'd1 << (MEAN_BITS - 1));

   // Statistics handed from the iterative unit to the top level
   typedef struct packed {
      logic signed [MEAN_BITS-1:0] mean_bias;
      logic [VAR_BITS-1:0]         variance;
      logic [RMS_BITS-1:0]         rms_error;
   } esa_result_type;

endpackage

// ===== src/esa_stat_unit.sv =====
// Iterative statistics unit: bit-serial divider and digit-by-digit square root
// that share one compare-subtract. Depends on esa_pkg.

module esa_stat_unit (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   input  logic signed [esa_pkg::ERR_SUM_BITS-1:0] error_sum,
   input  logic [esa_pkg::SQ_SUM_BITS-1:0]         squared_error_sum,
   input  logic [esa_pkg::COUNT_BITS-1:0]          sample_count,
   output logic                                    done,
   output esa_pkg::esa_result_type                 result
);

   typedef enum logic [6:0] {
      U_IDLE = 7'b0000001,
      U_MEAN = 7'b0000010,
      U_MSQ  = 7'b0000100,
      U_BIAS = 7'b0001000,
      U_VAR  = 7'b0010000,
      U_ROOT = 7'b0100000,
      U_DONE = 7'b1000000
   } unit_state_type;

   unit_state_type                         state_ff, state_in;
   logic [esa_pkg::STEP_BITS-1:0]          step_ff, step_in;
   logic [esa_pkg::WORK_BITS-1:0]          work_ff, work_in;
   logic [esa_pkg::PART_BITS-1:0]          part_ff, part_in;
   logic [esa_pkg::QUOT_BITS-1:0]          quot_ff, quot_in;
   logic                                   neg_ff, neg_in;
   logic                                   zero_ff, zero_in;
   logic signed [esa_pkg::MEAN_BITS-1:0]   mean_ff, mean_in;
   logic [esa_pkg::VAR_BITS-1:0]           msq_ff, msq_in;
   logic [esa_pkg::BSQ_BITS-1:0]           bsq_ff, bsq_in;
   logic [esa_pkg::VAR_BITS-1:0]           var_ff, var_in;

   logic [esa_pkg::CS_BITS-1:0]            cs_a, cs_b;
   logic [esa_pkg::CS_BITS:0]              cs_diff;
   logic                                   cs_ge;
   logic [esa_pkg::PART_BITS-1:0]          part_div_next, part_root_next;
   logic [esa_pkg::QUOT_BITS-1:0]          quot_next;
   logic [esa_pkg::ERR_SUM_BITS-1:0]       err_bits, err_mag;
   logic [esa_pkg::MEAN_BITS-1:0]          mean_mag, bias_mag;
   logic [esa_pkg::B2_BITS-1:0]            b2, msq_ext, var_diff;

   // Shared compare-subtract: divider step or square root step
   always_comb begin
      if (state_ff == U_ROOT) begin
         cs_a = {part_ff, work_ff[esa_pkg::WORK_BITS-1 -: 2]};
         cs_b = {1'b0, quot_ff[esa_pkg::RMS_BITS-1:0], 2'b01};
      end else begin
         cs_a = {{(esa_pkg::CS_BITS-esa_pkg::COUNT_BITS-1){1'b0}},
                 part_ff[esa_pkg::COUNT_BITS-1:0], work_ff[esa_pkg::WORK_BITS-1]};
         cs_b = {{(esa_pkg::CS_BITS-esa_pkg::COUNT_BITS){1'b0}}, sample_count};
      end
      cs_diff = {1'b0, cs_a} - {1'b0, cs_b};
      cs_ge   = ~cs_diff[esa_pkg::CS_BITS];
   end

   // Next partial remainder and quotient / root bits
   always_comb begin
      part_div_next  = {{(esa_pkg::PART_BITS-esa_pkg::COUNT_BITS){1'b0}},
                        cs_ge ? cs_diff[esa_pkg::COUNT_BITS-1:0]
                              : cs_a[esa_pkg::COUNT_BITS-1:0]};
      part_root_next = cs_ge ? cs_diff[esa_pkg::PART_BITS-1:0]
                             : cs_a[esa_pkg::PART_BITS-1:0];
      quot_next      = {quot_ff[esa_pkg::QUOT_BITS-2:0], cs_ge};
   end

   // Magnitude of the error sum, signed and clamped mean, bias square term
   always_comb begin
      err_bits = error_sum;
      err_mag  = err_bits[esa_pkg::ERR_SUM_BITS-1] ? (~err_bits + 1'b1) : err_bits;

      if (neg_ff) begin
         mean_mag = (quot_next > esa_pkg::MEAN_NEG_LIMIT)
                    ? esa_pkg::MEAN_NEG_LIMIT[esa_pkg::MEAN_BITS-1:0]
                    : quot_next[esa_pkg::MEAN_BITS-1:0];
      end else begin
         mean_mag = (quot_next > esa_pkg::MEAN_POS_LIMIT)
                    ? esa_pkg::MEAN_POS_LIMIT[esa_pkg::MEAN_BITS-1:0]
                    : quot_next[esa_pkg::MEAN_BITS-1:0];
      end

      bias_mag = mean_ff[esa_pkg::MEAN_BITS-1] ? (~mean_ff + 1'b1) : mean_ff;
      b2       = bsq_ff[esa_pkg::BSQ_BITS-1:esa_pkg::FRAC_BITS];
      msq_ext  = {{(esa_pkg::B2_BITS-esa_pkg::VAR_BITS){1'b0}}, msq_ff};
      var_diff = msq_ext - b2;
   end

   // Sequencer: mean divide, mean-square divide, bias square, variance, root
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      work_in  = work_ff;
      part_in  = part_ff;
      quot_in  = quot_ff;
      neg_in   = neg_ff;
      zero_in  = zero_ff;
      mean_in  = mean_ff;
      msq_in   = msq_ff;
      bsq_in   = bsq_ff;
      var_in   = var_ff;
      done     = 1'b0;

      unique case (state_ff)
         U_IDLE: begin
            if (start) begin
               work_in  = {err_mag, {(esa_pkg::WORK_BITS-esa_pkg::ERR_SUM_BITS){1'b0}}};
               part_in  = '0;
               quot_in  = '0;
               step_in  = esa_pkg::MEAN_LAST;
               neg_in   = err_bits[esa_pkg::ERR_SUM_BITS-1];
               zero_in  = (sample_count == '0);
               state_in = U_MEAN;
            end
         end
         U_MEAN: begin
            work_in = {work_ff[esa_pkg::WORK_BITS-2:0], 1'b0};
            part_in = part_div_next;
            quot_in = quot_next;
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               mean_in  = neg_ff ? -$signed(mean_mag) : $signed(mean_mag);
               work_in  = {squared_error_sum, {(2*esa_pkg::FRAC_BITS){1'b0}}};
               part_in  = '0;
               quot_in  = '0;
               step_in  = esa_pkg::MSQ_LAST;
               state_in = U_MSQ;
            end
         end
         U_MSQ: begin
            work_in = {work_ff[esa_pkg::WORK_BITS-2:0], 1'b0};
            part_in = part_div_next;
            quot_in = quot_next;
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               msq_in   = quot_next[esa_pkg::QUOT_BITS-1:esa_pkg::FRAC_BITS];
               work_in  = {quot_next, {(esa_pkg::WORK_BITS-esa_pkg::QUOT_BITS){1'b0}}};
               state_in = U_BIAS;
            end
         end
         U_BIAS: begin
            bsq_in   = bias_mag * bias_mag;
            state_in = U_VAR;
         end
         U_VAR: begin
            // clamp a negative variance to zero
            var_in   = (msq_ext > b2) ? var_diff[esa_pkg::VAR_BITS-1:0] : '0;
            part_in  = '0;
            quot_in  = '0;
            step_in  = esa_pkg::ROOT_LAST;
            state_in = U_ROOT;
         end
         U_ROOT: begin
            work_in = {work_ff[esa_pkg::WORK_BITS-3:0], 2'b00};
            part_in = part_root_next;
            quot_in = quot_next;
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = U_DONE;
            end
         end
         U_DONE: begin
            done     = 1'b1;
            state_in = U_IDLE;
         end
         default: begin
            state_in = U_IDLE;
         end
      endcase
   end

   // Hold results until the next start; an empty count reports zeros
   always_comb begin
      result.mean_bias = zero_ff ? '0 : mean_ff;
      result.variance  = zero_ff ? '0 : var_ff;
      result.rms_error = zero_ff ? '0 : quot_ff[esa_pkg::RMS_BITS-1:0];
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      step_ff <= step_in;
      work_ff <= work_in;
      part_ff <= part_in;
      quot_ff <= quot_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
      mean_ff <= mean_in;
      msq_ff  <= msq_in;
      bsq_ff  <= bsq_in;
      var_ff  <= var_in;
   end

endmodule

// ===== src/error_statistics_accumulator.sv =====
// Error statistics accumulator: running error sums, count and result register.
// Depends on esa_pkg and esa_stat_unit.
//
//   channel  direction  handshake           payload
//   req_     in         req_valid/req_stall  estimate, truth, first
//   rsp_     out        rsp_valid/rsp_stall  sample_count, mean_bias, variance,
//                                            rms_error, count_full
//
// A response is valid after its request has run through the bit-serial divider (49 steps
// for the mean, 78 for the mean square) and the 28-step square root on one 31-bit
// compare-subtract; the next request can be taken once the response is loaded.
// req_stall is high from acceptance until the response is loaded into the
// output register; a stalled response holds while the next request is taken.
// Reset clears the sums and the count at once; there is no clearing pass.

module error_statistics_accumulator (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [esa_pkg::SAMPLE_BITS-1:0] req_estimate,
   input  logic signed [esa_pkg::SAMPLE_BITS-1:0] req_truth,
   input  logic                                   req_first,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [esa_pkg::COUNT_BITS-1:0]         rsp_sample_count,
   output logic signed [esa_pkg::MEAN_BITS-1:0]   rsp_mean_bias,
   output logic [esa_pkg::VAR_BITS-1:0]           rsp_variance,
   output logic [esa_pkg::RMS_BITS-1:0]           rsp_rms_error,
   output logic                                   rsp_count_full
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SQUARE = 6'b000010,
      ST_ADD    = 6'b000100,
      ST_LAUNCH = 6'b001000,
      ST_WAIT   = 6'b010000,
      ST_LOAD   = 6'b100000
   } acc_state_type;

   acc_state_type                             state_ff, state_in;
   logic signed [esa_pkg::ERR_SUM_BITS-1:0]   err_sum_ff, err_sum_in;
   logic [esa_pkg::SQ_SUM_BITS-1:0]           sq_sum_ff, sq_sum_in;
   logic [esa_pkg::COUNT_BITS-1:0]            count_ff, count_in;
   logic [esa_pkg::DIFF_BITS-1:0]             diff_ff;
   logic [esa_pkg::SQR_BITS-1:0]              sqr_ff;
   logic                                      full_ff;
   logic                                      rsp_valid_ff, rsp_valid_in;

   logic                                      accept;
   logic                                      load_fire;
   logic [esa_pkg::DIFF_BITS-1:0]             diff_in;
   logic [esa_pkg::DIFF_BITS-1:0]             diff_mag;
   logic                                      unit_done;
   esa_pkg::esa_result_type                   unit_result;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign load_fire = (state_ff == ST_LOAD) && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Error and its magnitude
   assign diff_in  = {req_estimate[esa_pkg::SAMPLE_BITS-1], req_estimate}
                   - {req_truth[esa_pkg::SAMPLE_BITS-1], req_truth};
   assign diff_mag = diff_ff[esa_pkg::DIFF_BITS-1] ? (~diff_ff + 1'b1) : diff_ff;

   // Sequence: square, add, run the statistics unit, load the response
   always_comb begin
      state_in   = state_ff;
      err_sum_in = err_sum_ff;
      sq_sum_in  = sq_sum_ff;
      count_in   = count_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_first) begin
                  err_sum_in = '0;
                  sq_sum_in  = '0;
                  count_in   = '0;
               end
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            state_in = ST_ADD;
         end
         ST_ADD: begin
            // drop the sample when the count is saturated
            if (!full_ff) begin
               err_sum_in = err_sum_ff
                  + {{(esa_pkg::ERR_SUM_BITS-esa_pkg::DIFF_BITS){diff_ff[esa_pkg::DIFF_BITS-1]}},
                     diff_ff};
               sq_sum_in  = sq_sum_ff
                  + {{(esa_pkg::SQ_SUM_BITS-esa_pkg::SQR_BITS){1'b0}}, sqr_ff};
               count_in   = count_ff + 1'b1;
            end
            state_in = ST_LAUNCH;
         end
         ST_LAUNCH: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (unit_done) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (load_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = load_fire || (rsp_valid_ff && rsp_stall);
   end

   esa_stat_unit u_stat (
      .clock             (clock),
      .reset             (reset),
      .start             (state_ff == ST_LAUNCH),
      .error_sum         (err_sum_ff),
      .squared_error_sum (sq_sum_ff),
      .sample_count      (count_ff),
      .done              (unit_done),
      .result            (unit_result)
   );

   // Control state and accumulators
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         err_sum_ff   <= '0;
         sq_sum_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         err_sum_ff   <= err_sum_in;
         sq_sum_ff    <= sq_sum_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the request, square the error, load the response
   always_ff @(posedge clock) begin
      if (accept) begin
         diff_ff <= diff_in;
         full_ff <= !req_first && (count_ff == esa_pkg::COUNT_MAX);
      end
      if (state_ff == ST_SQUARE) begin
         sqr_ff <= diff_mag * diff_mag;
      end
      if (load_fire) begin
         rsp_sample_count <= count_ff;
         rsp_mean_bias    <= unit_result.mean_bias;
         rsp_variance     <= unit_result.variance;
         rsp_rms_error    <= unit_result.rms_error;
         rsp_count_full   <= full_ff;
      end
   end

endmodule

// ===== tb/error_stats_checker.sv =====
`timescale 1ns / 100ps
// Response checker for the error statistics accumulator: watches both channels,
// predicts each response from accepted requests and compares it. Depends on esa_pkg.

module error_stats_checker
   import esa_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_estimate,
   input  logic signed [SAMPLE_BITS-1:0] req_truth,
   input  logic                          req_first,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [COUNT_BITS-1:0]         rsp_sample_count,
   input  logic signed [MEAN_BITS-1:0]   rsp_mean_bias,
   input  logic [VAR_BITS-1:0]           rsp_variance,
   input  logic [RMS_BITS-1:0]           rsp_rms_error,
   input  logic                          rsp_count_full,
   output int                            pending_results,
   output int                            mismatch_count
);

   localparam logic [63:0] MEAN_POS_MAG = (64'd1 << (MEAN_BITS - 1)) - 64'd1;
   localparam logic [63:0] MEAN_NEG_MAG = 64'd1 << (MEAN_BITS - 1);
   localparam logic [63:0] VAR_LIMIT    = (64'd1 << VAR_BITS) - 64'd1;
   localparam logic [63:0] RMS_LIMIT    = (64'd1 << RMS_BITS) - 64'd1;

   typedef struct {
      logic [COUNT_BITS-1:0]       sample_count;
      logic signed [MEAN_BITS-1:0] mean_bias;
      logic [VAR_BITS-1:0]         variance;
      logic [RMS_BITS-1:0]         rms_error;
      logic                        count_full;
   } error_stats_type;

   // Running sums as the block should hold them
   longint                err_total;
   logic [63:0]           sq_err_total;
   logic [COUNT_BITS-1:0] n_samples;

   error_stats_type expected_stats_q[$];

   // floor(dividend * 2^shift / divisor), saturated to 64 bits
   function automatic logic [63:0] scaled_quotient(logic [63:0] dividend,
                                                   logic [63:0] divisor,
                                                   int unsigned shift);
      logic [127:0] q;
      q = ({64'd0, dividend} << shift) / {64'd0, divisor};
      return (q[127:64] != '0) ? '1 : q[63:0];
   endfunction

   // Largest root whose square does not exceed x
   function automatic logic [63:0] floor_sqrt(logic [63:0] x);
      logic [127:0] trial;
      logic [63:0]  root;
      root = '0;
      for (int b = 31; b >= 0; b--) begin
         trial = {64'd0, root | (64'd1 << b)};
         if (trial * trial <= {64'd0, x}) root = trial[63:0];
      end
      return root;
   endfunction

   // Fold one sample into the sums and work out the statistics it reports.
   // A saturated count needs 2^COUNT_BITS - 1 samples, far beyond one run,
   // but the prediction still covers it.
   function automatic error_stats_type accumulate_error(logic signed [SAMPLE_BITS-1:0] est,
                                                        logic signed [SAMPLE_BITS-1:0] tru,
                                                        logic clear);
      error_stats_type stats;
      longint          diff;
      longint          mean_val;
      logic [63:0]     mag, err_mag, mean_mag, msq, b2, var_v, rms_v;
      stats.count_full = 1'b0;
      mean_val         = 0;
      var_v            = '0;
      rms_v            = '0;

      if (clear) begin
         err_total    = 0;
         sq_err_total = '0;
         n_samples    = '0;
      end

      if (n_samples == COUNT_MAX) begin
         stats.count_full = 1'b1;
      end else begin
         diff         = longint'(est) - longint'(tru);
         mag          = (diff < 0) ? 64'(-diff) : 64'(diff);
         err_total    = err_total + diff;
         sq_err_total = sq_err_total + mag * mag;
         n_samples    = n_samples + 1'b1;
      end

      if (n_samples != '0) begin
         // mean bias truncates toward zero, then saturates
         err_mag  = (err_total < 0) ? 64'(-err_total) : 64'(err_total);
         mean_mag = scaled_quotient(err_mag, 64'(n_samples), FRAC_BITS);
         if (err_total < 0) begin
            if (mean_mag > MEAN_NEG_MAG) mean_mag = MEAN_NEG_MAG;
            mean_val = -longint'(mean_mag);
         end else begin
            if (mean_mag > MEAN_POS_MAG) mean_mag = MEAN_POS_MAG;
            mean_val = longint'(mean_mag);
         end

         // variance: mean square minus bias squared, clamped at zero
         msq   = scaled_quotient(sq_err_total, 64'(n_samples), FRAC_BITS);
         b2    = (mean_mag * mean_mag) >> FRAC_BITS;
         var_v = (msq > b2) ? msq - b2 : 64'd0;
         if (var_v > VAR_LIMIT) var_v = VAR_LIMIT;

         // RMS keeps FRAC_BITS fraction bits through the root
         rms_v = floor_sqrt(scaled_quotient(sq_err_total, 64'(n_samples), 2 * FRAC_BITS));
         if (rms_v > RMS_LIMIT) rms_v = RMS_LIMIT;
      end

      stats.sample_count = n_samples;
      stats.mean_bias    = mean_val[MEAN_BITS-1:0];
      stats.variance     = var_v[VAR_BITS-1:0];
      stats.rms_error    = rms_v[RMS_BITS-1:0];
      return stats;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] expected, logic [63:0] got);
      $display("%0t: mismatch in %s: expected 0x%0h, got 0x%0h", $realtime, what,
               expected, got);
      mismatch_count++;
   endtask

   // Predict on every accepted request, compare on every accepted response
   always @(posedge clock) begin
      error_stats_type want;
      if (reset) begin
         err_total       = 0;
         sq_err_total    = '0;
         n_samples       = '0;
         mismatch_count  = 0;
         expected_stats_q.delete();
      end else begin
         if (req_valid && !req_stall) begin
            expected_stats_q.push_back(accumulate_error(req_estimate, req_truth, req_first));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_stats_q.size() == 0) begin
               report_mismatch("response with no request waiting", '0, 64'(rsp_sample_count));
            end else begin
               want = expected_stats_q.pop_front();
               if (rsp_sample_count !== want.sample_count)
                  report_mismatch("sample_count", 64'(want.sample_count), 64'(rsp_sample_count));
               if (rsp_mean_bias !== want.mean_bias)
                  report_mismatch("mean_bias", 64'(want.mean_bias), 64'(rsp_mean_bias));
               if (rsp_variance !== want.variance)
                  report_mismatch("variance", 64'(want.variance), 64'(rsp_variance));
               if (rsp_rms_error !== want.rms_error)
                  report_mismatch("rms_error", 64'(want.rms_error), 64'(rsp_rms_error));
               if (rsp_count_full !== want.count_full)
                  report_mismatch("count_full", 64'(want.count_full), 64'(rsp_count_full));
            end
         end
      end
      pending_results = expected_stats_q.size();
   end

endmodule

// ===== tb/tb_error_statistics_accumulator.sv =====
`timescale 1ns / 100ps
// Top of the error statistics accumulator testbench: clock, reset, request
// stimulus, response stalls and the verdict. Depends on esa_pkg and error_stats_checker.

module tb_error_statistics_accumulator;
   import esa_pkg::*;

   localparam int unsigned QUIET_LIMIT   = 20000;
   localparam int unsigned SETTLE_CYCLES = 400;
   localparam int unsigned PHASE_ITEMS   = 457;

   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   typedef enum int {RUN_FULL_RANGE, RUN_NEAR_TRUTH, RUN_CONSTANT, RUN_EXTREMES} run_style_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic signed [SAMPLE_BITS-1:0] req_estimate = '0;
   logic signed [SAMPLE_BITS-1:0] req_truth = '0;
   logic                          req_first = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [COUNT_BITS-1:0]         rsp_sample_count;
   logic signed [MEAN_BITS-1:0]   rsp_mean_bias;
   logic [VAR_BITS-1:0]           rsp_variance;
   logic [RMS_BITS-1:0]           rsp_rms_error;
   logic                          rsp_count_full;
   int                            pending_results;
   int                            mismatch_count;

   int unsigned sender_idle_pct = 0;
   int unsigned stall_pct       = 0;

   error_statistics_accumulator i_dut (.*);

   error_stats_checker i_checker (.*);

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Stall responses at the rate of the current phase
   always @(posedge clock) begin
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
   end

   // End the run when nothing is accepted for too long
   initial begin : watchdog
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("Some tests failed");
      $finish;
   end

   // Present one request, with random idle cycles ahead of it, and hold until taken
   task automatic send_request(logic signed [SAMPLE_BITS-1:0] est,
                               logic signed [SAMPLE_BITS-1:0] tru, logic clear);
      while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_estimate <= est;
      req_truth    <= tru;
      req_first    <= clear;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Drop valid and hold off until every response has come back
   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
   endtask

   function automatic logic signed [SAMPLE_BITS-1:0] clamp_sample(int v);
      if (v > int'(SAMPLE_MAX)) return SAMPLE_MAX;
      if (v < int'(SAMPLE_MIN)) return SAMPLE_MIN;
      return v[SAMPLE_BITS-1:0];
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] pick_extreme();
      case ($urandom_range(3))
         0:       return SAMPLE_MAX;
         1:       return SAMPLE_MIN;
         2:       return '0;
         default: return '1;
      endcase
   endfunction

   // Runs of samples that mostly start with a clear, each with its own error profile
   task automatic run_random_phase(int unsigned item_goal);
      int unsigned                   sent;
      int unsigned                   run_len;
      run_style_type                 style;
      int                            bias;
      logic signed [SAMPLE_BITS-1:0] est, tru;
      logic                          clear;
      sent = 0;
      while (sent < item_goal) begin
         run_len = ($urandom_range(19) == 0) ? $urandom_range(300, 100) : $urandom_range(40, 1);
         style   = run_style_type'($urandom_range(3));
         bias    = int'($urandom_range(2000)) - 1000;
         for (int unsigned k = 0; k < run_len; k++) begin
            clear = (k == 0) ? ($urandom_range(9) != 0) : ($urandom_range(49) == 0);
            tru   = SAMPLE_BITS'($urandom);
            case (style)
               RUN_FULL_RANGE: est = SAMPLE_BITS'($urandom);
               RUN_NEAR_TRUTH: est = clamp_sample(int'(tru) + bias + int'($urandom_range(64)) - 32);
               RUN_CONSTANT:   est = clamp_sample(int'(tru) + bias);
               default: begin
                  est = pick_extreme();
                  tru = pick_extreme();
               end
            endcase
            send_request(est, tru, clear);
            sent++;
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Zero error, then the largest errors of both signs
      send_request('0, '0, 1'b1);
      send_request(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
      send_request(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
      send_request(SAMPLE_MIN, SAMPLE_MIN, 1'b0);
      send_request(SAMPLE_MAX, SAMPLE_MAX, 1'b0);
      // Negative bias after a clear
      send_request(SAMPLE_MIN, '0, 1'b1);
      send_request(SAMPLE_BITS'(-1), '0, 1'b0);
      send_request('0, SAMPLE_MAX, 1'b0);
      // Constant error: variance comes out zero
      send_request(SAMPLE_BITS'(5), SAMPLE_BITS'(2), 1'b1);
      send_request(SAMPLE_BITS'(-7), SAMPLE_BITS'(-10), 1'b0);
      send_request(SAMPLE_BITS'(100), SAMPLE_BITS'(97), 1'b0);
      send_request(SAMPLE_MAX, SAMPLE_MAX - SAMPLE_BITS'(3), 1'b0);
      // Alternating extreme errors: bias near zero, largest variance
      send_request(SAMPLE_MAX, SAMPLE_MIN, 1'b1);
      send_request(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
      send_request(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
      send_request(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
      // Repeated largest error: largest mean and RMS
      send_request(SAMPLE_MAX, SAMPLE_MIN, 1'b1);
      send_request(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
      send_request(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
      // Small negative mean truncates toward zero
      send_request('0, SAMPLE_BITS'(1), 1'b1);
      send_request('0, '0, 1'b0);
      send_request('0, '0, 1'b0);
      // Back-to-back clears
      send_request(SAMPLE_BITS'(1), '0, 1'b1);
      send_request('0, SAMPLE_BITS'(1), 1'b1);
      drain_responses();

      // Random runs under each pacing mix
      run_random_phase(PHASE_ITEMS);
      drain_responses();

      sender_idle_pct = 87;
      stall_pct       = 0;
      run_random_phase(PHASE_ITEMS);
      drain_responses();

      sender_idle_pct = 0;
      stall_pct       = 87;
      run_random_phase(PHASE_ITEMS);
      drain_responses();

      sender_idle_pct = 34;
      stall_pct       = 34;
      run_random_phase(PHASE_ITEMS);
      drain_responses();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
